// ----- design/dual_channel_paced_sample_fifo_core_macros.svh -----
// assertion macros shared by the fifo core modules
`ifndef DUAL_CHANNEL_PACED_SAMPLE_FIFO_CORE_MACROS_SVH
`define DUAL_CHANNEL_PACED_SAMPLE_FIFO_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define DCPSF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dcpsf same-cycle check failed");

// next-cycle implication, checked out of reset
`define DCPSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dcpsf next-cycle check failed");

`endif

// ----- design/dcpsf_pkg.sv -----
// package: constants, types and helpers of the paced sample fifo core
package dcpsf_pkg;

    localparam int MAX_RING_DEPTH     = 1024;
    localparam int DEFAULT_RING_DEPTH = 128;
    localparam int POS_W              = $clog2(MAX_RING_DEPTH);
    localparam int SAMPLE_W           = 8;
    localparam int PERIOD_W           = 32;
    localparam int REQ_SIZE_W         = 16;
    localparam int CFG_DATA_W         = 32;

    localparam logic [SAMPLE_W-1:0] SILENCE_LEVEL = SAMPLE_W'(128);

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_PERIOD = 2'd1,
        REQ_TICK   = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_RING_SIZE  = 2'd0,
        CFG_PERIOD_CH0 = 2'd1,
        CFG_PERIOD_CH1 = 2'd2,
        CFG_ENABLE     = 2'd3
    } cfg_index_t;

    // one transaction as seen by a channel, already qualified
    typedef struct packed {
        logic                push;
        logic                set_period;
        logic                tick;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
        logic [PERIOD_W-1:0] period;
    } chan_cmd_t;

    // register writes that touch a channel
    typedef struct packed {
        logic                flush;
        logic                load_period;
        logic [PERIOD_W-1:0] period;
        logic                silence;
    } chan_cfg_t;

    // channel state after the current transaction
    typedef struct packed {
        logic                accepted;
        logic [POS_W-1:0]    space_left;
        logic [SAMPLE_W-1:0] held;
        logic                fired;
        logic                underrun;
    } chan_status_t;

    // ring index mask: capacity (128 if zero or over 1024) rounded up to a power of two, minus one
    function automatic logic [POS_W-1:0] ring_mask_of(input logic [REQ_SIZE_W-1:0] req);
        logic [REQ_SIZE_W-1:0] want;
        logic [POS_W-1:0]      m;
        if (req == '0 || req > REQ_SIZE_W'(MAX_RING_DEPTH)) begin
            want = REQ_SIZE_W'(DEFAULT_RING_DEPTH);
        end else begin
            want = req;
        end
        m = POS_W'(want - REQ_SIZE_W'(1));
        m = m | (m >> 1);
        m = m | (m >> 2);
        m = m | (m >> 4);
        m = m | (m >> 8);
        return m;
    endfunction

endpackage

// ----- design/dcpsf_ring_ram.sv -----
// sample ring storage: one write port, one registered read port
module dcpsf_ring_ram (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [dcpsf_pkg::POS_W-1:0]    wr_addr,
    input  logic [dcpsf_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [dcpsf_pkg::POS_W-1:0]    rd_addr,
    output logic [dcpsf_pkg::SAMPLE_W-1:0] rd_data
);

    logic [dcpsf_pkg::SAMPLE_W-1:0] mem [dcpsf_pkg::MAX_RING_DEPTH];
    logic [dcpsf_pkg::SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/dcpsf_channel.sv -----
// one audio channel: ring pointers, burst refusal, playout timer, held output
module dcpsf_channel (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [dcpsf_pkg::POS_W-1:0]  mask,
    input  dcpsf_pkg::chan_cmd_t         cmd,
    input  dcpsf_pkg::chan_cfg_t         cfg,
    output dcpsf_pkg::chan_status_t      status
);

    `include "dual_channel_paced_sample_fifo_core_macros.svh"

    logic [dcpsf_pkg::POS_W-1:0]    wp_reg, wp_next;
    logic [dcpsf_pkg::POS_W-1:0]    rp_reg, rp_next;
    logic                           burst_reg, burst_next;
    logic [dcpsf_pkg::PERIOD_W-1:0] count_reg, count_next;
    logic [dcpsf_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [dcpsf_pkg::SAMPLE_W-1:0] held_reg, held_next;

    logic                           byp_hit_reg;
    logic [dcpsf_pkg::SAMPLE_W-1:0] byp_data_reg;
    logic [dcpsf_pkg::SAMPLE_W-1:0] ram_rd_data;
    logic [dcpsf_pkg::SAMPLE_W-1:0] head_data;

    logic [dcpsf_pkg::POS_W-1:0]    free_now;
    logic                           empty;
    logic                           can_push;
    logic                           accepted;
    logic [dcpsf_pkg::PERIOD_W-1:0] period_eff;
    logic                           due;
    logic                           fired;

    // head sample prefetched at the read pointer, with write bypass
    assign head_data = byp_hit_reg ? byp_data_reg : ram_rd_data;

    assign empty      = (rp_reg == wp_reg);
    assign free_now   = mask - ((wp_reg - rp_reg) & mask);
    assign can_push   = !burst_reg && (free_now != '0);
    assign accepted   = cmd.push && can_push;
    assign period_eff = (period_reg == '0) ? dcpsf_pkg::PERIOD_W'(1) : period_reg;
    assign due        = (count_reg >= period_eff - dcpsf_pkg::PERIOD_W'(1));
    assign fired      = cmd.tick && due;

    always_comb begin
        wp_next     = wp_reg;
        rp_next     = rp_reg;
        burst_next  = burst_reg;
        count_next  = count_reg;
        period_next = period_reg;
        held_next   = held_reg;

        if (cfg.flush) begin
            wp_next    = '0;
            rp_next    = '0;
            burst_next = 1'b0;
        end else begin
            if (accepted) begin
                wp_next = (wp_reg + dcpsf_pkg::POS_W'(1)) & mask;
            end else if (cmd.push) begin
                burst_next = !cmd.last;
            end
            if (fired && !empty) begin
                rp_next = (rp_reg + dcpsf_pkg::POS_W'(1)) & mask;
            end
        end

        if (cfg.load_period) begin
            period_next = cfg.period;
            count_next  = '0;
        end else begin
            if (cmd.set_period) begin
                period_next = cmd.period;
            end
            if (cmd.tick) begin
                count_next = due ? '0 : count_reg + dcpsf_pkg::PERIOD_W'(1);
            end
        end

        if (cfg.silence) begin
            held_next = dcpsf_pkg::SILENCE_LEVEL;
        end else if (fired) begin
            held_next = empty ? dcpsf_pkg::SILENCE_LEVEL : head_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg     <= '0;
            rp_reg     <= '0;
            burst_reg  <= 1'b0;
            count_reg  <= '0;
            period_reg <= '0;
            held_reg   <= dcpsf_pkg::SILENCE_LEVEL;
        end else begin
            wp_reg     <= wp_next;
            rp_reg     <= rp_next;
            burst_reg  <= burst_next;
            count_reg  <= count_next;
            period_reg <= period_next;
            held_reg   <= held_next;
        end
    end

    // bypass when the slot about to become head is written this cycle
    always_ff @(posedge aclk) begin
        byp_hit_reg  <= accepted && (wp_reg == rp_next);
        byp_data_reg <= cmd.sample;
    end

    dcpsf_ring_ram u_ram (
        .aclk    (aclk),
        .wr_en   (accepted),
        .wr_addr (wp_reg),
        .wr_data (cmd.sample),
        .rd_addr (rp_next),
        .rd_data (ram_rd_data)
    );

    assign status.accepted   = accepted;
    assign status.space_left = mask - ((wp_next - rp_next) & mask);
    assign status.held       = held_next;
    assign status.fired      = fired;
    assign status.underrun   = fired && empty;

    `DCPSF_ASSERT_SAME(a_ptrs_in_ring, 1'b1, ((wp_reg & ~mask) == '0) && ((rp_reg & ~mask) == '0))
    `DCPSF_ASSERT_NEXT(a_push_advances, accepted && !cfg.flush,
        wp_reg == (($past(wp_reg) + dcpsf_pkg::POS_W'(1)) & $past(mask)))

endmodule

// ----- design/dual_channel_paced_sample_fifo_core.sv -----
// top level: two paced sample rings behind a registered transaction pipeline
//
// Two 8-bit audio channels, each with a power-of-two sample ring and its own
// playout period timer. A transaction pushes a sample (refused when the ring
// is full, and for the rest of a burst once one sample was refused), sets a
// channel's period, or, while enabled, delivers one tick to both timers. A
// timer that fires takes the oldest sample of its ring, or silence (128) with
// an underrun flag when the ring is empty. Every transaction returns one
// result: accept flag, free slots of the addressed channel, both held
// outputs (128 while disabled) and the fire and underrun flags. Throughput
// is one transaction per cycle while the result is not held back; each
// transaction passes through the input register, then the result register,
// and back-pressure can hold it in either. The ring memories are read at the
// next read pointer on every cycle and registered, so the head sample is
// always waiting when a timer fires. No clearing pass after reset: ring
// entries are only read once written. Register writes take effect at once
// and must be made only while no transaction is in flight.
module dual_channel_paced_sample_fifo_core (
    input  logic                            aclk,
    input  logic                            aresetn,

    // register write port
    input  logic                            cfg_wr_en,
    input  logic [1:0]                      cfg_index,
    input  logic [dcpsf_pkg::CFG_DATA_W-1:0] cfg_data,

    // transaction input
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_req_type,
    input  logic                            s_channel,
    input  logic [dcpsf_pkg::SAMPLE_W-1:0]   s_sample,
    input  logic                            s_last_of_burst,
    input  logic [dcpsf_pkg::PERIOD_W-1:0]   s_period,

    // result output
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_accepted,
    output logic [dcpsf_pkg::POS_W-1:0]      m_space_left,
    output logic [dcpsf_pkg::SAMPLE_W-1:0]   m_dac0_value,
    output logic [dcpsf_pkg::SAMPLE_W-1:0]   m_dac1_value,
    output logic                            m_dac0_fired,
    output logic                            m_dac1_fired,
    output logic                            m_dac0_underrun,
    output logic                            m_dac1_underrun
);

    `include "dual_channel_paced_sample_fifo_core_macros.svh"

    // input register
    logic                           in_valid_reg, in_valid_next;
    logic [1:0]                     in_req_reg;
    logic                           in_channel_reg;
    logic [dcpsf_pkg::SAMPLE_W-1:0] in_sample_reg;
    logic                           in_last_reg;
    logic [dcpsf_pkg::PERIOD_W-1:0] in_period_reg;

    // result register
    logic                           out_valid_reg, out_valid_next;
    logic                           out_accepted_reg;
    logic [dcpsf_pkg::POS_W-1:0]    out_space_reg;
    logic [dcpsf_pkg::SAMPLE_W-1:0] out_dac0_reg;
    logic [dcpsf_pkg::SAMPLE_W-1:0] out_dac1_reg;
    logic                           out_fired0_reg;
    logic                           out_fired1_reg;
    logic                           out_under0_reg;
    logic                           out_under1_reg;

    // configuration state
    logic [dcpsf_pkg::POS_W-1:0]    mask_reg, mask_next;
    logic                           enable_reg, enable_next;

    logic                           s_fire;
    logic                           process;
    logic                           is_push;
    logic                           is_period;
    logic                           is_tick;

    dcpsf_pkg::chan_cmd_t           cmd0, cmd1;
    dcpsf_pkg::chan_cfg_t           cfg0, cfg1;
    dcpsf_pkg::chan_status_t        st0, st1;

    // the held transaction moves on when the result register is free or draining
    assign process = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign s_fire  = s_valid && s_ready;

    assign in_valid_next  = s_fire ? 1'b1 : (process ? 1'b0 : in_valid_reg);
    assign out_valid_next = process ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    // request decode; the unused code leaves the channel state alone
    assign is_push   = process && (in_req_reg == dcpsf_pkg::REQ_PUSH);
    assign is_period = process && (in_req_reg == dcpsf_pkg::REQ_PERIOD);
    assign is_tick   = process && (in_req_reg == dcpsf_pkg::REQ_TICK) && enable_reg;

    always_comb begin
        cmd0.push       = is_push && !in_channel_reg;
        cmd0.set_period = is_period && !in_channel_reg;
        cmd0.tick       = is_tick;
        cmd0.sample     = in_sample_reg;
        cmd0.last       = in_last_reg;
        cmd0.period     = in_period_reg;

        cmd1.push       = is_push && in_channel_reg;
        cmd1.set_period = is_period && in_channel_reg;
        cmd1.tick       = is_tick;
        cmd1.sample     = in_sample_reg;
        cmd1.last       = in_last_reg;
        cmd1.period     = in_period_reg;
    end

    // register writes
    always_comb begin
        mask_next   = mask_reg;
        enable_next = enable_reg;
        cfg0        = '0;
        cfg1        = '0;
        cfg0.period = cfg_data;
        cfg1.period = cfg_data;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                dcpsf_pkg::CFG_RING_SIZE: begin
                    mask_next  = dcpsf_pkg::ring_mask_of(cfg_data[dcpsf_pkg::REQ_SIZE_W-1:0]);
                    cfg0.flush = 1'b1;
                    cfg1.flush = 1'b1;
                end
                dcpsf_pkg::CFG_PERIOD_CH0: begin
                    cfg0.load_period = 1'b1;
                end
                dcpsf_pkg::CFG_PERIOD_CH1: begin
                    cfg1.load_period = 1'b1;
                end
                dcpsf_pkg::CFG_ENABLE: begin
                    enable_next  = cfg_data[0];
                    cfg0.silence = !cfg_data[0];
                    cfg1.silence = !cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= dcpsf_pkg::ring_mask_of('0);
            enable_reg    <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            mask_reg      <= mask_next;
            enable_reg    <= enable_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg     <= s_req_type;
            in_channel_reg <= s_channel;
            in_sample_reg  <= s_sample;
            in_last_reg    <= s_last_of_burst;
            in_period_reg  <= s_period;
        end
        if (process) begin
            out_accepted_reg <= st0.accepted || st1.accepted;
            out_space_reg    <= in_channel_reg ? st1.space_left : st0.space_left;
            out_dac0_reg     <= enable_reg ? st0.held : dcpsf_pkg::SILENCE_LEVEL;
            out_dac1_reg     <= enable_reg ? st1.held : dcpsf_pkg::SILENCE_LEVEL;
            out_fired0_reg   <= st0.fired;
            out_fired1_reg   <= st1.fired;
            out_under0_reg   <= st0.underrun;
            out_under1_reg   <= st1.underrun;
        end
    end

    dcpsf_channel u_ch0 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mask    (mask_reg),
        .cmd     (cmd0),
        .cfg     (cfg0),
        .status  (st0)
    );

    dcpsf_channel u_ch1 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .mask    (mask_reg),
        .cmd     (cmd1),
        .cfg     (cfg1),
        .status  (st1)
    );

    assign m_valid         = out_valid_reg;
    assign m_accepted      = out_accepted_reg;
    assign m_space_left    = out_space_reg;
    assign m_dac0_value    = out_dac0_reg;
    assign m_dac1_value    = out_dac1_reg;
    assign m_dac0_fired    = out_fired0_reg;
    assign m_dac1_fired    = out_fired1_reg;
    assign m_dac0_underrun = out_under0_reg;
    assign m_dac1_underrun = out_under1_reg;

    // input side stalls only when both stages are full and the result is held
    `DCPSF_ASSERT_SAME(a_ready_only_blocked_when_full, !s_ready,
        in_valid_reg && out_valid_reg && !m_ready)
    // an underrun is always a fire that put out silence
    `DCPSF_ASSERT_SAME(a_underrun_gives_silence, m_valid && m_dac0_underrun,
        m_dac0_fired && (m_dac0_value == dcpsf_pkg::SILENCE_LEVEL))

endmodule
